// ===== hdl/cms_pkg.sv =====
// ----------------------------------------------------------------------------
// cms_pkg: CAN message segmenter shared definitions
// Transaction types, frame layout constants and length limits.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

    localparam int unsigned CHUNK_BYTES = 7;
    localparam int unsigned MAX_FRAMES  = 128;

    localparam logic [9:0] LEN_LIMIT  = 10'(CHUNK_BYTES * MAX_FRAMES);
    localparam logic [9:0] SINGLE_MAX = 10'd8;
    localparam logic [3:0] CHUNK_FILL = 4'(CHUNK_BYTES);

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_LEN = 1'b1;

    typedef struct packed {
        logic [10:0] frame_id;
        logic [9:0]  msg_length;
        logic [7:0]  data_byte;
    } msg_t;

    typedef struct packed {
        logic [10:0] out_id;
        logic [3:0]  dlc;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
        logic        status;
        logic        message_done;
    } frame_t;

endpackage

`default_nettype wire

// ===== hdl/can_message_segmenter_top.sv =====
// The frame for an accepted final-byte (or bad-length) transaction is registered
// into the frame output register, or into the skid register if the output stalls.
// Throughput: one byte per cycle while msg_ready is high; the frame output register
// plus one skid register keep msg_ready high while a single frame waits downstream.
// Reset (rst_n low, asynchronous) clears message state and the valid flags of both output stages.
// ----------------------------------------------------------------------------
// can_message_segmenter_top: CAN message segmenter
// Packs a byte stream into CAN data frames, single-frame or with a
// sequence header per frame; flags invalid message lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module can_message_segmenter_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            msg_valid,
    output logic                 msg_ready,
    input  wire cms_pkg::msg_t   msg,
    output logic                 frame_valid,
    input  wire logic            frame_ready,
    output cms_pkg::frame_t      frame
);
    import cms_pkg::*;

    logic             in_message_reg, in_message_next;
    logic [10:0]      held_id_reg, held_id_next;
    logic [9:0]       held_length_reg, held_length_next;
    logic [9:0]       bytes_taken_reg, bytes_taken_next;
    logic [7:0][7:0]  frame_buf_reg, frame_buf_next;
    logic [3:0]       fill_count_reg, fill_count_next;
    logic [6:0]       seq_num_reg, seq_num_next;

    logic             out_valid_reg, out_valid_next;
    frame_t           out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    frame_t           skid_data_reg, skid_data_next;

    logic             accept;
    logic             res_valid;
    frame_t           res_data;

    logic             start;
    logic [10:0]      cur_id;
    logic [9:0]       cur_len;
    logic [9:0]       cur_taken;
    logic [3:0]       cur_fill;
    logic [6:0]       cur_seq;
    logic [7:0][7:0]  cur_buf;
    logic [7:0][7:0]  new_buf;
    logic             multi;
    logic [2:0]       pos;
    logic [3:0]       fill_inc;
    logic [9:0]       taken_inc;
    logic             last;
    logic             bad_len;

    assign msg_ready = !skid_valid_reg;
    assign accept    = msg_valid && msg_ready;

    always_comb
    begin
        start     = !in_message_reg;
        bad_len   = start && (msg.msg_length == 10'd0 || msg.msg_length > LEN_LIMIT);
        cur_id    = start ? msg.frame_id   : held_id_reg;
        cur_len   = start ? msg.msg_length : held_length_reg;
        cur_taken = start ? 10'd0 : bytes_taken_reg;
        cur_fill  = start ? 4'd0  : fill_count_reg;
        cur_seq   = start ? 7'd0  : seq_num_reg;
        cur_buf   = start ? '0    : frame_buf_reg;

        multi     = cur_len > SINGLE_MAX;
        pos       = multi ? 3'(cur_fill + 4'd1) : cur_fill[2:0];
        new_buf   = cur_buf;
        new_buf[pos] = cur_buf[pos] | msg.data_byte;
        fill_inc  = cur_fill + 4'd1;
        taken_inc = cur_taken + 10'd1;
        last      = taken_inc >= cur_len;

        in_message_next  = in_message_reg;
        held_id_next     = held_id_reg;
        held_length_next = held_length_reg;
        bytes_taken_next = bytes_taken_reg;
        frame_buf_next   = frame_buf_reg;
        fill_count_next  = fill_count_reg;
        seq_num_next     = seq_num_reg;

        res_valid = 1'b0;
        res_data  = '0;

        if (accept)
        begin
            if (bad_len)
            begin
                res_valid             = 1'b1;
                res_data.out_id       = msg.frame_id;
                res_data.status       = STATUS_BAD_LEN;
                res_data.message_done = 1'b1;
            end
            else
            begin
                in_message_next  = 1'b1;
                held_id_next     = cur_id;
                held_length_next = cur_len;
                bytes_taken_next = taken_inc;
                frame_buf_next   = new_buf;
                fill_count_next  = fill_inc;
                seq_num_next     = cur_seq;

                if (!multi)
                begin
                    if (last)
                    begin
                        res_valid             = 1'b1;
                        res_data.out_id       = cur_id;
                        res_data.dlc          = cur_len[3:0];
                        res_data.byte0        = new_buf[0];
                        res_data.byte1        = new_buf[1];
                        res_data.byte2        = new_buf[2];
                        res_data.byte3        = new_buf[3];
                        res_data.byte4        = new_buf[4];
                        res_data.byte5        = new_buf[5];
                        res_data.byte6        = new_buf[6];
                        res_data.byte7        = new_buf[7];
                        res_data.status       = STATUS_OK;
                        res_data.message_done = 1'b1;
                        in_message_next       = 1'b0;
                        frame_buf_next        = '0;
                        fill_count_next       = 4'd0;
                    end
                end
                else if (fill_inc >= CHUNK_FILL || last)
                begin
                    res_valid             = 1'b1;
                    res_data.out_id       = cur_id;
                    res_data.dlc          = fill_inc + 4'd1;
                    res_data.byte0        = {last, cur_seq};
                    res_data.byte1        = new_buf[1];
                    res_data.byte2        = new_buf[2];
                    res_data.byte3        = new_buf[3];
                    res_data.byte4        = new_buf[4];
                    res_data.byte5        = new_buf[5];
                    res_data.byte6        = new_buf[6];
                    res_data.byte7        = new_buf[7];
                    res_data.status       = STATUS_OK;
                    res_data.message_done = last;
                    seq_num_next          = cur_seq + 7'd1;
                    fill_count_next       = 4'd0;
                    frame_buf_next        = '0;
                    if (last)
                    begin
                        in_message_next = 1'b0;
                    end
                end
            end
        end
    end

    // output stage plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;

        if (out_valid_reg && !frame_ready)
        begin
            if (res_valid)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_data;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_data_next   = skid_data_reg;
            skid_valid_next = res_valid;
            skid_data_next  = res_data;
        end
        else
        begin
            out_valid_next = res_valid;
            out_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg  <= 1'b0;
            held_id_reg     <= '0;
            held_length_reg <= '0;
            bytes_taken_reg <= '0;
            frame_buf_reg   <= '0;
            fill_count_reg  <= '0;
            seq_num_reg     <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            in_message_reg  <= in_message_next;
            held_id_reg     <= held_id_next;
            held_length_reg <= held_length_next;
            bytes_taken_reg <= bytes_taken_next;
            frame_buf_reg   <= frame_buf_next;
            fill_count_reg  <= fill_count_next;
            seq_num_reg     <= seq_num_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign frame_valid = out_valid_reg;
    assign frame       = out_data_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds a frame while the output stage is empty");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_valid && frame.status == STATUS_BAD_LEN) |->
            (frame.message_done && frame.dlc == 4'd0))
        else $error("length error transaction is malformed");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_message_reg |-> (fill_count_reg < 4'd8))
        else $error("frame fill count overran the frame");

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        in_message_reg |-> (bytes_taken_reg < held_length_reg))
        else $error("message still open after its last byte");
`endif

endmodule

`default_nettype wire

// ===== test/tb_can_message_segmenter_top.sv =====
// ----------------------------------------------------------------------------
// tb_can_message_segmenter_top: self-checking bench for the CAN segmenter
// Streams whole messages byte by byte (directed corner cases, then random
// lengths, bad lengths and one long multi-frame message) with random idle and
// backpressure, predicts every frame and checks each one field by field.
// ----------------------------------------------------------------------------

import cms_pkg::*;

class can_frame_predictor;

    frame_t      pending_frames[$];
    int unsigned mismatches;
    int unsigned frames_checked;
    int unsigned bad_length_frames;
    int unsigned multi_frames;

    logic        busy;
    logic [10:0] cur_id;
    logic [9:0]  cur_len;
    logic [9:0]  byte_count;
    logic [63:0] frame_bytes;
    logic [3:0]  chunk_fill;
    logic [6:0]  seq_num;

    function new();
        busy        = 1'b0;
        cur_id      = '0;
        cur_len     = '0;
        byte_count  = '0;
        frame_bytes = '0;
        chunk_fill  = '0;
        seq_num     = '0;
    endfunction

    function void take_byte(msg_t m);
        frame_t      f;
        logic        multi;
        logic        last;
        int unsigned pos;
        f = '0;
        if (!busy) begin
            if (m.msg_length == 10'd0 || m.msg_length > LEN_LIMIT) begin
                f.out_id       = m.frame_id;
                f.status       = STATUS_BAD_LEN;
                f.message_done = 1'b1;
                pending_frames.push_back(f);
                return;
            end
            cur_id      = m.frame_id;
            cur_len     = m.msg_length;
            busy        = 1'b1;
            byte_count  = '0;
            chunk_fill  = '0;
            frame_bytes = '0;
            seq_num     = '0;
        end
        multi = cur_len > SINGLE_MAX;
        pos   = (multi ? chunk_fill + 1 : chunk_fill) & 7;
        frame_bytes[8*pos +: 8] = m.data_byte;
        chunk_fill = chunk_fill + 4'd1;
        byte_count = byte_count + 10'd1;
        last       = byte_count >= cur_len;
        if (!multi && !last)
            return;
        if (multi && chunk_fill < CHUNK_FILL && !last)
            return;
        if (multi) begin
            frame_bytes[7:0] = {last, seq_num};
            f.dlc   = chunk_fill + 4'd1;
            seq_num = seq_num + 7'd1;
            multi_frames++;
        end
        else begin
            f.dlc = cur_len[3:0];
        end
        f.out_id       = cur_id;
        f.byte0        = frame_bytes[7:0];
        f.byte1        = frame_bytes[15:8];
        f.byte2        = frame_bytes[23:16];
        f.byte3        = frame_bytes[31:24];
        f.byte4        = frame_bytes[39:32];
        f.byte5        = frame_bytes[47:40];
        f.byte6        = frame_bytes[55:48];
        f.byte7        = frame_bytes[63:56];
        f.status       = STATUS_OK;
        f.message_done = last;
        chunk_fill  = '0;
        frame_bytes = '0;
        if (last)
            busy = 1'b0;
        pending_frames.push_back(f);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void match_frame(frame_t got);
        frame_t want;
        if (pending_frames.size() == 0) begin
            $display("%0t: unexpected frame, expected none actual id 0x%0h dlc %0d",
                     $time, got.out_id, got.dlc);
            mismatches++;
            return;
        end
        want = pending_frames.pop_front();
        frames_checked++;
        if (want.status == STATUS_BAD_LEN)
            bad_length_frames++;
        check_field("out_id",       want.out_id,       got.out_id);
        check_field("dlc",          want.dlc,          got.dlc);
        check_field("byte0",        want.byte0,        got.byte0);
        check_field("byte1",        want.byte1,        got.byte1);
        check_field("byte2",        want.byte2,        got.byte2);
        check_field("byte3",        want.byte3,        got.byte3);
        check_field("byte4",        want.byte4,        got.byte4);
        check_field("byte5",        want.byte5,        got.byte5);
        check_field("byte6",        want.byte6,        got.byte6);
        check_field("byte7",        want.byte7,        got.byte7);
        check_field("status",       want.status,       got.status);
        check_field("message_done", want.message_done, got.message_done);
    endfunction

endclass

module tb_can_message_segmenter_top;

    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned RANDOM_ITEMS = 360;
    localparam logic [9:0]  LONG_LEN     = 10'd175;

    localparam int DATA_RANDOM = 0;
    localparam int DATA_ONES   = 1;
    localparam int DATA_ZEROS  = 2;

    logic   clk;
    logic   rst_n;
    logic   msg_valid;
    logic   msg_ready;
    msg_t   msg;
    logic   frame_valid;
    logic   frame_ready;
    frame_t frame;

    can_frame_predictor sb;

    int unsigned bytes_driven;
    int unsigned messages_sent;
    int unsigned idle_cycles;
    bit          send_burst;
    bit          recv_burst;

    can_message_segmenter_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_ready   (msg_ready),
        .msg         (msg),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    always #4 clk = ~clk;

    task automatic drive_byte(msg_t m);
        int unsigned gap;
        if (($urandom % 40) == 0)
            send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg       <= m;
        msg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!msg_ready);
        sb.take_byte(m);
        bytes_driven++;
    endtask

    task automatic send_message(logic [10:0] id, logic [9:0] len, int unsigned n_bytes,
                                int data_kind);
        msg_t        m;
        int unsigned sel;
        for (int unsigned i = 0; i < n_bytes; i++) begin
            m.frame_id   = (i == 0) ? id  : 11'($urandom);
            m.msg_length = (i == 0) ? len : 10'($urandom);
            sel          = $urandom_range(0, 7);
            case (data_kind)
                DATA_ONES:  m.data_byte = 8'hFF;
                DATA_ZEROS: m.data_byte = 8'h00;
                default:    m.data_byte = (sel == 0) ? 8'h00 :
                                          (sel == 1) ? 8'hFF : 8'($urandom);
            endcase
            drive_byte(m);
        end
        messages_sent++;
    endtask

    task automatic drain_frames();
        msg_valid <= 1'b0;
        while (sb.pending_frames.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall before each frame, with bursts of none
    initial begin
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever begin
            if (($urandom % 40) == 0)
                recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                frame_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            frame_ready <= 1'b1;
            do
                @(posedge clk);
            while (!frame_valid);
            sb.match_frame(frame);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (msg_valid && msg_ready) || (frame_valid && frame_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("can_message_segmenter_top verification failed");
        $finish;
    end

    initial begin
        int unsigned r;
        logic [9:0]  len;
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        msg_valid     = 1'b0;
        msg           = '0;
        frame_ready   = 1'b0;
        bytes_driven  = 0;
        messages_sent = 0;
        send_burst    = 1'b0;
        recv_burst    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_message(11'd0,     10'd0,    1, DATA_RANDOM);
        send_message(11'h7FF,   10'd897,  1, DATA_RANDOM);
        send_message(11'h555,   10'd1023, 1, DATA_ONES);
        send_message(11'd0,     10'd1,    1, DATA_ZEROS);
        send_message(11'h7FF,   10'd8,    8, DATA_ONES);
        send_message(11'h2AA,   10'd9,    9, DATA_RANDOM);

        // hold off until every frame is out
        drain_frames();

        while (bytes_driven < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                len = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom_range(897, 1023));
                send_message(11'($urandom), len, 1, DATA_RANDOM);
            end
            else begin
                len = (r < 55) ? 10'($urandom_range(1, 8))  :
                      (r < 90) ? 10'($urandom_range(9, 40)) : 10'($urandom_range(41, 120));
                send_message(11'($urandom), len, len, DATA_RANDOM);
            end
            if (($urandom % 25) == 0)
                drain_frames();
        end

        // long message, 25 header frames in a row
        send_message(11'($urandom), LONG_LEN, LONG_LEN, DATA_RANDOM);

        msg_valid <= 1'b0;
        drain_frames();
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes in %0d messages; checked %0d frames", bytes_driven,
                 messages_sent, sb.frames_checked);
        $display("  (%0d length errors, %0d header frames, %0d mismatches)",
                 sb.bad_length_frames, sb.multi_frames, sb.mismatches);
        if (sb.mismatches == 0)
            $display("can_message_segmenter_top verification clean");
        else
            $display("can_message_segmenter_top verification failed");
        $finish;
    end

endmodule
